// ===== sv/gmps_pkg.sv =====
package gmps_pkg;

  localparam int unsigned COST_W = 8;
  localparam int unsigned SUM_W  = 24;
  localparam int unsigned LEN_W  = 9;

  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [COST_W-1:0] cost_t;
  typedef logic [LEN_W-1:0]  len_t;

  localparam sum_t SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic advance;
    logic restart;
  } cell_ctl_t;

  function automatic sum_t sat_add(input sum_t a, input cost_t b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W + 1 - COST_W){1'b0}}, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

// ===== sv/grid_min_path_sum.sv =====
// Channel | Direction | Transfer when          | Contents
// in_     | slave     | in_tvalid & in_tready  | cell cost in tdata, last cell in tlast
// out_    | master    | out_tvalid & out_tready| saturated minimum path sum in tdata
// cfg_    | write     | cfg_we                 | row length in cfg_wdata
//
// One cell per cycle while in_tready is high; tlast's sum is valid the next cycle.
// A ring of MAX_COLS cells holds the best sum per column; a one-hot token
// walks the ring and each cell prefetches the above value for the next item.
// Reset clears control, token and row length to 1; cell values stay unknown.
// in_tready drops only for a last cell while an untaken path sum waits.
module grid_min_path_sum #(
  parameter int unsigned MAX_COLS = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] cell_cost
  input  logic                          in_tlast,   // last_cell
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [23:0]                   out_tdata,  // [23:0] path_sum
  input  logic                          cfg_we,
  input  logic [gmps_pkg::LEN_W-1:0]    cfg_wdata
);

  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned EW = $clog2(MAX_COLS + 1);
  localparam int unsigned XW = (EW > gmps_pkg::LEN_W) ? EW : gmps_pkg::LEN_W;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_COLS);

  gmps_pkg::len_t      len_r;
  logic [CW-1:0]       col_r;
  logic [CW-1:0]       col_nxt;
  logic                first_row_r;
  logic                first_row_nxt;
  gmps_pkg::sum_t      left_r;
  gmps_pkg::sum_t      left_nxt;
  gmps_pkg::sum_t      above_r;
  gmps_pkg::sum_t      above_nxt;
  gmps_pkg::sum_t      best;
  gmps_pkg::sum_t      pick;
  gmps_pkg::sum_t      sum_r;
  logic                out_valid_r;
  logic                accept;
  logic                wrap;
  logic [XW-1:0]       len_x;
  logic [XW-1:0]       cols_x;
  logic [XW-1:0]       col_inc;
  gmps_pkg::cell_ctl_t ctl;
  logic [MAX_COLS-1:0] token;
  gmps_pkg::sum_t      contrib [MAX_COLS];

  assign in_tready  = !out_valid_r || out_tready || !in_tlast;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = sum_r;

  always_comb begin
    len_x = XW'(len_r);
    if (len_x == '0) begin
      cols_x = XW'(1);
    end else if (len_x > MAX_X) begin
      cols_x = MAX_X;
    end else begin
      cols_x = len_x;
    end
  end

  assign col_inc = XW'(col_r) + XW'(1);
  assign wrap    = (col_inc >= cols_x);

  always_comb begin
    if (first_row_r || col_r == '0) begin
      pick = first_row_r ? left_r : above_r;
    end else begin
      pick = (above_r < left_r) ? above_r : left_r;
    end
    if (first_row_r && col_r == '0) begin
      best = gmps_pkg::sum_t'(in_tdata);
    end else begin
      best = gmps_pkg::sat_add(pick, in_tdata);
    end
  end

  assign ctl.advance = accept;
  assign ctl.restart = accept && (wrap || in_tlast);

  for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
    gmps_cell #(.IS_HEAD(i == 0)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .token_in (token[(i + MAX_COLS - 1) % MAX_COLS]),
      .best     (best),
      .token_out(token[i]),
      .contrib  (contrib[i])
    );
  end

  always_comb begin
    above_nxt = '0;
    for (int i = 0; i < MAX_COLS; i++) begin
      above_nxt = above_nxt | contrib[i];
    end
  end

  always_comb begin
    col_nxt       = col_inc[CW-1:0];
    first_row_nxt = first_row_r;
    left_nxt      = best;
    if (wrap) begin
      col_nxt       = '0;
      first_row_nxt = 1'b0;
    end
    if (in_tlast) begin
      col_nxt       = '0;
      first_row_nxt = 1'b1;
      left_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= gmps_pkg::len_t'(1);
      col_r       <= '0;
      first_row_r <= 1'b1;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
      if (accept) begin
        col_r       <= col_nxt;
        first_row_r <= first_row_nxt;
        left_r      <= left_nxt;
      end
      if (accept && in_tlast) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      above_r <= above_nxt;
    end
    if (accept && in_tlast) begin
      sum_r <= best;
    end
  end

endmodule

// ===== sv/gmps_cell.sv =====
module gmps_cell #(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gmps_pkg::cell_ctl_t ctl,
  input  logic                token_in,
  input  gmps_pkg::sum_t      best,
  output logic                token_out,
  output gmps_pkg::sum_t      contrib
);

  logic           token_r;
  logic           token_nxt;
  logic           wr;
  gmps_pkg::sum_t val_r;

  // advance the column token; restart returns it to the head cell
  always_comb begin
    if (ctl.restart) begin
      token_nxt = IS_HEAD;
    end else if (ctl.advance) begin
      token_nxt = token_in;
    end else begin
      token_nxt = token_r;
    end
  end

  assign wr = ctl.advance & token_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_r <= IS_HEAD;
    end else begin
      token_r <= token_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      val_r <= best;
    end
  end

  // offer this column's value when the token lands here next, with bypass
  assign contrib   = token_nxt ? (wr ? best : val_r) : '0;
  assign token_out = token_r;

endmodule
